// ===== rtl/trgr_pkg.sv =====
package trgr_pkg;

  localparam int BANK_SIZE_DEF = 2048;
  localparam int GLYPH_ROWS    = 8;
  localparam int ROW_W         = 3;
  localparam int CODE_W        = 8;
  localparam int COLOR_W       = 4;
  localparam int ROM_ADDR_W    = 12;
  localparam int ROM_DATA_W    = 8;
  localparam int PIX_BYTE_W    = 8;
  localparam int PIX_W         = GLYPH_ROWS * PIX_BYTE_W;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 4;

  localparam logic [CODE_W-1:0]    SPACE_CODE      = 8'd32;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BANK  = 1'b1;

  typedef enum logic {
    OP_RENDER = 1'b0,
    OP_LOAD   = 1'b1
  } op_e;

  typedef struct packed {
    op_e                   operation;
    logic [CODE_W-1:0]     char_code;
    logic [COLOR_W-1:0]    fg_color;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [ROM_DATA_W-1:0] rom_data;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [PIX_W-1:0] row_pixels;
    logic             last_row;
  } out_item_t;

  // one glyph row request travelling alongside the memory read
  typedef struct packed {
    logic               space;
    logic [COLOR_W-1:0] fg_color;
    logic [ROW_W-1:0]   row_index;
    logic               last_row;
  } row_req_t;

  // byte k takes fg where glyph bit 7-k is set, bg elsewhere
  function automatic logic [PIX_W-1:0] glyph_pixels(
    input logic [ROM_DATA_W-1:0] bits,
    input logic [COLOR_W-1:0]    fg,
    input logic [COLOR_W-1:0]    bg
  );
    logic [PIX_W-1:0] pix;
    pix = '0;
    for (int k = 0; k < GLYPH_ROWS; k++) begin
      pix[k*PIX_BYTE_W +: PIX_BYTE_W] =
        PIX_BYTE_W'(bits[GLYPH_ROWS-1-k] ? fg : bg);
    end
    return pix;
  endfunction

endpackage

// ===== rtl/trgr_glyph_mem.sv =====
module trgr_glyph_mem #(
  parameter int DEPTH  = 2 * trgr_pkg::BANK_SIZE_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [ADDR_W-1:0]               waddr_i,
  input  logic [trgr_pkg::ROM_DATA_W-1:0] wdata_i,
  input  logic                            re_i,
  input  logic [ADDR_W-1:0]               raddr_i,
  output logic [trgr_pkg::ROM_DATA_W-1:0] rdata_o
);

  logic [trgr_pkg::ROM_DATA_W-1:0] mem [DEPTH];
  logic [trgr_pkg::ROM_DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/trgr_row_seq.sv =====
module trgr_row_seq #(
  parameter int BANK_SIZE = trgr_pkg::BANK_SIZE_DEF,
  parameter int ADDR_W    = $clog2(2 * BANK_SIZE)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  trgr_pkg::in_item_t              in_item_i,
  output logic                            in_stall_o,
  input  logic                            bank_i,
  input  logic                            rd_free_i,
  output logic                            req_valid_o,
  output trgr_pkg::row_req_t              req_o,
  output logic                            mem_re_o,
  output logic [ADDR_W-1:0]               mem_raddr_o,
  output logic                            mem_we_o,
  output logic [ADDR_W-1:0]               mem_waddr_o,
  output logic [trgr_pkg::ROM_DATA_W-1:0] mem_wdata_o
);

  localparam int OFF_W = $clog2(BANK_SIZE);
  localparam int RED_W = OFF_W + 3;
  localparam int MEM_DEPTH = 2 * BANK_SIZE;
  localparam logic [trgr_pkg::ROW_W-1:0] LAST_ROW = trgr_pkg::ROW_W'(trgr_pkg::GLYPH_ROWS - 1);

  // (code * 8) mod bank size, code * 8 stays below 8 banks
  function automatic logic [OFF_W-1:0] start_offset(input logic [trgr_pkg::CODE_W-1:0] code);
    logic [RED_W-1:0] v;
    v = RED_W'({code, 3'b000});
    for (int i = 2; i >= 0; i--) begin
      if (v >= RED_W'(BANK_SIZE << i)) begin
        v = v - RED_W'(BANK_SIZE << i);
      end
    end
    return v[OFF_W-1:0];
  endfunction

  logic                              busy_q, busy_d;
  logic [trgr_pkg::ROW_W-1:0]        row_q, row_d;
  logic [OFF_W-1:0]                  off_q, off_d;
  logic                              space_q, space_d;
  logic [trgr_pkg::COLOR_W-1:0]      fg_q, fg_d;
  logic                              last;
  logic                              issue;
  logic                              free;
  logic                              accept;

  assign last   = (row_q == LAST_ROW);
  assign issue  = busy_q && rd_free_i;
  assign free   = !busy_q || (issue && last);
  assign accept = in_valid_i && free;

  assign in_stall_o = !free;

  always_comb begin
    busy_d  = busy_q;
    row_d   = row_q;
    off_d   = off_q;
    space_d = space_q;
    fg_d    = fg_q;
    if (issue) begin
      row_d = row_q + 1'b1;
      off_d = (off_q == OFF_W'(BANK_SIZE - 1)) ? '0 : off_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (accept && in_item_i.operation == trgr_pkg::OP_RENDER) begin
      busy_d  = 1'b1;
      row_d   = '0;
      off_d   = start_offset(in_item_i.char_code);
      space_d = (in_item_i.char_code == trgr_pkg::SPACE_CODE);
      fg_d    = in_item_i.fg_color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q   <= off_d;
    space_q <= space_d;
    fg_q    <= fg_d;
  end

  assign req_valid_o     = issue;
  assign req_o.space     = space_q;
  assign req_o.fg_color  = fg_q;
  assign req_o.row_index = row_q;
  assign req_o.last_row  = last;

  assign mem_re_o    = issue && !space_q;
  assign mem_raddr_o = ADDR_W'(off_q) + (bank_i ? ADDR_W'(BANK_SIZE) : '0);

  // loads beyond both banks can never be read back
  assign mem_we_o    = accept && (in_item_i.operation == trgr_pkg::OP_LOAD)
                       && ((trgr_pkg::ROM_ADDR_W + 1)'(in_item_i.rom_address)
                           < (trgr_pkg::ROM_ADDR_W + 1)'(MEM_DEPTH));
  assign mem_waddr_o = in_item_i.rom_address[ADDR_W-1:0];
  assign mem_wdata_o = in_item_i.rom_data;

endmodule

// ===== rtl/trgr_pixel_out.sv =====
module trgr_pixel_out (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  trgr_pkg::row_req_t              req_i,
  output logic                            rd_free_o,
  input  logic [trgr_pkg::ROM_DATA_W-1:0] rdata_i,
  input  logic [trgr_pkg::COLOR_W-1:0]    bg_color_i,
  output logic                            out_valid_o,
  output trgr_pkg::out_item_t             out_item_o,
  input  logic                            out_stall_i
);

  logic                 rd_valid_q;
  trgr_pkg::row_req_t   rd_req_q;
  logic                 out_valid_q;
  trgr_pkg::out_item_t  out_item_q, out_item_d;
  logic                 out_adv;

  assign out_adv   = !out_valid_q || !out_stall_i;
  assign rd_free_o = !rd_valid_q || out_adv;

  always_comb begin
    out_item_d.row_index  = rd_req_q.row_index;
    out_item_d.last_row   = rd_req_q.last_row;
    out_item_d.row_pixels = rd_req_q.space
      ? trgr_pkg::glyph_pixels('0, rd_req_q.fg_color, bg_color_i)
      : trgr_pkg::glyph_pixels(rdata_i, rd_req_q.fg_color, bg_color_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_free_o) begin
        rd_valid_q <= req_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= rd_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_free_o && req_valid_i) begin
      rd_req_q <= req_i;
    end
    if (out_adv && rd_valid_q) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/text_mode_glyph_row_renderer_unit.sv =====
// a render's rows pass the row sequencer, the glyph memory read and the output register in turn
// one memory read per row, none for a space; a new request is taken as the last row issues
// the glyph memory's single read port sets the one-row-per-cycle pace unless the output stalls
// reset: asynchronous, active low; clears busy and row count, valid flags and config registers
// the glyph memory is not cleared and holds garbage until loaded
module text_mode_glyph_row_renderer_unit #(
  parameter int BANK_SIZE = trgr_pkg::BANK_SIZE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  input  trgr_pkg::in_item_t              in_item_i,
  output logic                            in_stall_o,
  // row result channel
  output logic                            out_valid_o,
  output trgr_pkg::out_item_t             out_item_o,
  input  logic                            out_stall_i,
  // config write port
  input  logic                            cfg_we_i,
  input  logic [trgr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [trgr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int MEM_DEPTH = 2 * BANK_SIZE;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // config registers
  logic [trgr_pkg::COLOR_W-1:0] bg_color_q;
  logic                         bank_q;

  // sequencer to read stage
  logic                            rd_free;
  logic                            req_valid;
  trgr_pkg::row_req_t              req;

  // glyph memory ports
  logic                            mem_re;
  logic [ADDR_W-1:0]               mem_raddr;
  logic                            mem_we;
  logic [ADDR_W-1:0]               mem_waddr;
  logic [trgr_pkg::ROM_DATA_W-1:0] mem_wdata;
  logic [trgr_pkg::ROM_DATA_W-1:0] mem_rdata;

  // config writes must land only while idle; the block does not enforce it, hence no shadowing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_color_q <= '0;
      bank_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        trgr_pkg::CFG_BACKGROUND: begin
          bg_color_q <= cfg_wdata_i[trgr_pkg::COLOR_W-1:0];
        end
        trgr_pkg::CFG_LOWER_BANK: begin
          bank_q <= cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // row sequencer: takes requests, writes loads to the glyph memory, walks the eight glyph rows of a cell
  trgr_row_seq #(
    .BANK_SIZE (BANK_SIZE),
    .ADDR_W    (ADDR_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .bank_i      (bank_q),
    .rd_free_i   (rd_free),
    .req_valid_o (req_valid),
    .req_o       (req),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  // glyph store, both banks, registered read
  trgr_glyph_mem #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // color expansion into the output register
  trgr_pixel_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .rd_free_o   (rd_free),
    .rdata_i     (mem_rdata),
    .bg_color_i  (bg_color_q),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  // an accepted render starts at row zero next cycle unless the read stage is blocked
  a_render_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.operation == trgr_pkg::OP_RENDER)
    |=> ((req_valid && req.row_index == '0) || !rd_free))
    else $error("render request did not start at row zero");

  // a cell keeps issuing rows until its last one, whenever the read stage is free
  a_rows_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && !req.last_row) |=> (req_valid || !rd_free))
    else $error("row sequence broke off before the last row");

  // last-row flag only on the bottom row
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.last_row
                     == (out_item_o.row_index
                         == trgr_pkg::ROW_W'(trgr_pkg::GLYPH_ROWS - 1))))
    else $error("last_row flag does not match row index");

endmodule

// ===== test/glyph_row_checker.sv =====
`timescale 1ns / 100ps
module glyph_row_checker
  import trgr_pkg::*;
#(
  parameter int BANK_SIZE = BANK_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  in_item_t              req_i,
  input  logic                  req_stall_i,
  input  logic                  row_valid_i,
  input  out_item_t             row_i,
  input  logic                  row_stall_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fault_count_o,
  output int                    rows_pending_o
);

  logic [ROM_DATA_W-1:0] glyph_store [0:(1 << ROM_ADDR_W)-1];
  logic [COLOR_W-1:0]    bg_color   = '0;
  logic                  lower_bank = 1'b0;
  out_item_t             expected_rows [$];
  out_item_t             want;
  logic [ROM_DATA_W-1:0] glyph;
  int                    glyph_addr;
  int                    faults = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      bg_color   = '0;
      lower_bank = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BACKGROUND: bg_color   = cfg_wdata_i[COLOR_W-1:0];
          CFG_LOWER_BANK: lower_bank = cfg_wdata_i[0];
          default: ;
        endcase
      end

      // rows leave before a new request can add any, so check first
      if (row_valid_i && !row_stall_i) begin
        if (expected_rows.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected row: idx %0d pix %h last %0b",
                     row_i.row_index, row_i.row_pixels, row_i.last_row);
        end else begin
          want = expected_rows.pop_front();
          if (row_i.row_index !== want.row_index || row_i.row_pixels !== want.row_pixels ||
              row_i.last_row !== want.last_row) begin
            faults++;
            if (faults <= 10)
              $display("row mismatch: expected idx %0d pix %h last %0b, got idx %0d pix %h last %0b",
                       want.row_index, want.row_pixels, want.last_row,
                       row_i.row_index, row_i.row_pixels, row_i.last_row);
          end
        end
      end

      if (req_valid_i && !req_stall_i) begin
        if (req_i.operation == OP_LOAD) begin
          glyph_store[req_i.rom_address] = req_i.rom_data;
        end else begin
          for (int r = 0; r < GLYPH_ROWS; r++) begin
            glyph_addr = (int'(lower_bank) * BANK_SIZE
                          + (int'(req_i.char_code) * GLYPH_ROWS + r) % BANK_SIZE)
                         % (1 << ROM_ADDR_W);
            // space never touches the glyph store
            glyph = (req_i.char_code == SPACE_CODE) ? '0 : glyph_store[glyph_addr];
            want.row_index = ROW_W'(r);
            want.last_row  = (r == GLYPH_ROWS - 1);
            for (int k = 0; k < GLYPH_ROWS; k++)
              want.row_pixels[k*PIX_BYTE_W +: PIX_BYTE_W] =
                PIX_BYTE_W'(glyph[7-k] ? req_i.fg_color : bg_color);
            expected_rows.push_back(want);
          end
        end
      end
    end
    rows_pending_o <= expected_rows.size();
    fault_count_o  <= faults;
  end

endmodule

// ===== test/text_mode_glyph_row_renderer_unit_tb.sv =====
`timescale 1ns / 100ps
module text_mode_glyph_row_renderer_unit_tb;
  import trgr_pkg::*;

  localparam int DRAIN_CYCLES   = 12;    // wait after the last expected row, with margin
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request or row moving
  localparam int PRESSURE_HOLD  = 80;    // long receiver hold-off, in cycles
  localparam int PHASES         = 6;
  localparam int RANDOM_PER_PHASE = 38;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  in_item_t              in_item_i   = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  out_item_t             out_item_o;
  logic                  out_stall_i = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int   fault_count;
  int   rows_pending;
  int   requests_sent  = 0;
  int   quiet_cycles   = 0;
  bit   timed_out      = 1'b0;
  bit   pressure_armed = 1'b0;   // set by the stimulus, seen by the receiver
  bit   pressure_done  = 1'b0;
  logic cur_bank       = 1'b0;

  // codes whose eight glyph bytes are all loaded, per bank
  logic [CODE_W-1:0] ready_upper [$];
  logic [CODE_W-1:0] ready_lower [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  text_mode_glyph_row_renderer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  glyph_row_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (in_valid_i),
    .req_i          (in_item_i),
    .req_stall_i    (in_stall_o),
    .row_valid_i    (out_valid_o),
    .row_i          (out_item_o),
    .row_stall_i    (out_stall_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fault_count_o  (fault_count),
    .rows_pending_o (rows_pending)
  );

  // load request, render fields random since the block ignores them
  function automatic in_item_t make_load(input logic [ROM_ADDR_W-1:0] addr,
                                         input logic [ROM_DATA_W-1:0] data);
    in_item_t req;
    req.operation   = OP_LOAD;
    req.char_code   = CODE_W'($urandom);
    req.fg_color    = COLOR_W'($urandom);
    req.rom_address = addr;
    req.rom_data    = data;
    return req;
  endfunction

  // render request, load fields random since the block ignores them
  function automatic in_item_t make_render(input logic [CODE_W-1:0] code,
                                           input logic [COLOR_W-1:0] fg);
    in_item_t req;
    req.operation   = OP_RENDER;
    req.char_code   = code;
    req.fg_color    = fg;
    req.rom_address = ROM_ADDR_W'($urandom);
    req.rom_data    = ROM_DATA_W'($urandom);
    return req;
  endfunction

  // offer one request, with random idle cycles ahead of it, and hold it until taken
  task automatic send_request(input in_item_t req);
    // requests 70 to 129 go out back to back
    while (!(requests_sent >= 70 && requests_sent < 130) && $urandom_range(0, 99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // all eight rows of one glyph, row r taken from byte r of rows
  task automatic load_glyph(input logic bank, input logic [CODE_W-1:0] code,
                            input logic [63:0] rows);
    for (int r = 0; r < GLYPH_ROWS; r++)
      send_request(make_load(ROM_ADDR_W'(int'(bank) * BANK_SIZE_DEF
                                         + (int'(code) * GLYPH_ROWS + r) % BANK_SIZE_DEF),
                             rows[8*r +: 8]));
    if (bank) ready_lower.push_back(code);
    else ready_upper.push_back(code);
  endtask

  // both registers, back to back, only while the block is idle
  task automatic set_registers(input logic [COLOR_W-1:0] bg, input logic bank);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_BACKGROUND;
    cfg_wdata_i <= CFG_DATA_W'(bg);
    @(posedge clk_i);
    cfg_index_i <= CFG_LOWER_BANK;
    cfg_wdata_i <= CFG_DATA_W'(bank);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_bank = bank;
  endtask

  // wait for every expected row, then let a trailing load finish too
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rows_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // mostly full glyph loads followed by renders of loaded codes,
  // with spaces and stray single-byte loads as noise
  task automatic random_requests(input int count);
    int                issued;
    int                pick;
    int                avail;
    logic [CODE_W-1:0] code;
    issued = 0;
    while (issued < count) begin
      pick  = $urandom_range(0, 99);
      avail = cur_bank ? ready_lower.size() : ready_upper.size();
      if (pick < 25) begin
        load_glyph(1'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 255)),
                   {$urandom, $urandom});
        issued += GLYPH_ROWS;
      end else if (pick < 80 && avail > 0) begin
        code = cur_bank ? ready_lower[$urandom_range(0, avail - 1)]
                        : ready_upper[$urandom_range(0, avail - 1)];
        send_request(make_render(code, COLOR_W'($urandom_range(0, 15))));
        issued++;
      end else if (pick < 90) begin
        send_request(make_render(SPACE_CODE, COLOR_W'($urandom_range(0, 15))));
        issued++;
      end else begin
        send_request(make_load(ROM_ADDR_W'($urandom_range(0, 4095)),
                               ROM_DATA_W'($urandom_range(0, 255))));
        issued++;
      end
    end
  endtask

  // receiver: random stalls, a quiet stretch early on, and one long hold-off
  // once the stimulus arms it, so the block fills up and stalls its input
  initial begin
    int rx_cycle;
    int hold_left;
    rx_cycle  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (pressure_armed && !pressure_done && hold_left == 0) hold_left = PRESSURE_HOLD;
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
        if (hold_left == 0) pressure_done = 1'b1;
      end else if (rx_cycle >= 150 && rx_cycle < 300) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 36);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fork
      begin
        for (int p = 0; p < PHASES; p++) begin
          if (p > 0) settle();
          // background and bank per phase, extremes first, last one random
          case (p)
            0: set_registers(4'd0, 1'b0);
            1: set_registers(4'd15, 1'b1);
            2: set_registers(4'd10, 1'b0);
            3: set_registers(4'd15, 1'b0);
            4: set_registers(4'd0, 1'b1);
            default: set_registers(COLOR_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
          endcase

          if (p == 0) begin
            // code 0 in the upper bank: blank, solid, single-pixel edges, checkers
            load_glyph(1'b0, 8'd0, 64'hF00F_55AA_0180_FF00);
            // top code in the lower bank, top addresses of the store
            load_glyph(1'b1, 8'd255, 64'h8001_7EFF_C3A5_1824);
            send_request(make_render(8'd0, 4'd15));
            send_request(make_render(8'd0, 4'd0));
            send_request(make_render(SPACE_CODE, 4'd7));
            send_request(make_render(SPACE_CODE, 4'd15));
            send_request(make_render(8'd0, 4'd9));
          end

          // long receiver hold-off while requests keep coming
          if (p == 2) pressure_armed = 1'b1;
          random_requests(RANDOM_PER_PHASE);
        end
        settle();
      end
      begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
          @(posedge clk_i);
          if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
          else quiet_cycles++;
        end
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    if (!timed_out && fault_count == 0 && rows_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
